// ===== design/ert_pkg.sv =====
// ----------------------------------------------------------------------------
// ert_pkg: shared types and constants of the echo reply tracker
// Holds the duplicate window size, field layouts, status and register codes
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ert_pkg;

  // duplicate window, a power of two
  localparam int unsigned DupWindow = 1024;
  localparam int unsigned IdxW      = $clog2(DupWindow);

  localparam logic [31:0] TripMinReset = 32'd999999999;
  localparam logic [15:0] LengthReset  = 16'd68;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 160;
  localparam int unsigned OutDataW = 248;

  typedef logic [IdxW-1:0] slot_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgExpLength   = 3'd0,
    CfgExpClass    = 3'd1,
    CfgExpKind     = 3'd2,
    CfgExpPort     = 3'd3,
    CfgExpTag      = 3'd4,
    CfgPacketLimit = 3'd5
  } cfg_reg_e;

  // result status codes
  typedef enum logic [2:0] {
    StatSent      = 3'd0,
    StatRefused   = 3'd1,
    StatReplyOk   = 3'd2,
    StatDuplicate = 3'd3,
    StatTooShort  = 3'd4,
    StatForeign   = 3'd5
  } status_e;

  // input data layout, last field in the lowest bits
  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] sent_time_ms;
    logic [15:0] reply_seq;
    logic [31:0] reply_tag;
    logic [15:0] reply_port;
    logic [7:0]  frame_kind;
    logic [7:0]  frame_class;
    logic [15:0] frame_length;
  } frame_t;

  // controller to datapath
  typedef struct packed {
    logic  load_in;
    logic  lookup;
    logic  exec;
    logic  clear_we;
    slot_t clear_addr;
  } ert_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } ert_sts_t;

endpackage

// ===== design/ert_ctrl.sv =====
// ----------------------------------------------------------------------------
// ert_ctrl: sequencing of the echo reply tracker
// Sweeps the seen bitmap after reset, then steps each item through
// accept, bitmap lookup and update.
// ----------------------------------------------------------------------------
module ert_ctrl
  import ert_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ert_sts_t sts_i,
  output ert_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    StClear  = 4'b0001,
    StIdle   = 4'b0010,
    StLookup = 4'b0100,
    StExec   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  slot_t  clr_q, clr_d;
  logic   clr_last;

  assign clr_last = (clr_q == slot_t'(DupWindow - 1));

  // next state and commands
  always_comb begin
    state_d         = state_q;
    clr_d           = clr_q;
    in_ready_o      = 1'b0;
    cmd_o           = '0;
    cmd_o.clear_addr = clr_q;
    unique case (state_q)
      StClear: begin
        cmd_o.clear_we = 1'b1;
        clr_d          = clr_q + slot_t'(1);
        if (clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = StLookup;
        end
      end
      StLookup: begin
        cmd_o.lookup = 1'b1;
        state_d      = StExec;
      end
      StExec: begin
        // wait until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

endmodule

// ===== design/ert_datapath.sv =====
// ----------------------------------------------------------------------------
// ert_datapath: registers, seen bitmap and statistics of the tracker
// Holds the configuration, the input item, the duplicate bitmap memory,
// the saturating counters and trip statistics, and the output register.
// ----------------------------------------------------------------------------
module ert_datapath
  import ert_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  frame_t              in_data_i,
  input  logic                in_type_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [OutDataW-1:0] out_data_o,
  output logic [2:0]          out_status_o,
  input  ert_cmd_t            cmd_i,
  output ert_sts_t            sts_o
);

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // configuration registers
  logic [15:0] exp_length_q;
  logic [7:0]  exp_class_q;
  logic [7:0]  exp_kind_q;
  logic [15:0] exp_port_q;
  logic [31:0] exp_tag_q;
  logic [31:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_length_q <= LengthReset;
      exp_class_q  <= '0;
      exp_kind_q   <= '0;
      exp_port_q   <= '0;
      exp_tag_q    <= '0;
      limit_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgExpLength:   exp_length_q <= cfg_data_i[15:0];
        CfgExpClass:    exp_class_q  <= cfg_data_i[7:0];
        CfgExpKind:     exp_kind_q   <= cfg_data_i[7:0];
        CfgExpPort:     exp_port_q   <= cfg_data_i[15:0];
        CfgExpTag:      exp_tag_q    <= cfg_data_i;
        CfgPacketLimit: limit_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input item register
  frame_t in_q;
  logic   type_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q   <= in_data_i;
      type_q <= in_type_i;
    end
  end

  // statistics state
  logic [31:0] sent_q, recv_q, dup_q, min_q, max_q, sum_q;
  logic        answered_q;
  logic [31:0] sent_d, recv_d, dup_d, min_d, max_d, sum_d;
  logic        answered_d;

  // seen bitmap
  logic  seen_mem [DupWindow];
  logic  seen_rd_q;
  logic  mem_we;
  slot_t mem_waddr;
  logic  mem_wdata;
  slot_t rd_slot;

  assign rd_slot = in_q.reply_seq[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seen_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.lookup) begin
      seen_rd_q <= seen_mem[rd_slot];
    end
  end

  // item evaluation
  logic        tx_ok, too_short, match, hit;
  logic [31:0] trip;
  logic [32:0] sum_ext;
  logic [15:0] seq_out;
  status_e     status;
  logic        limit_hit;

  always_comb begin
    trip      = in_q.now_ms - in_q.sent_time_ms;
    tx_ok     = (limit_q == '0) || (sent_q < limit_q);
    too_short = (in_q.frame_length < exp_length_q);
    match     = (in_q.frame_length == exp_length_q) && (in_q.frame_class == exp_class_q) &&
                (in_q.frame_kind == exp_kind_q) && (in_q.reply_port == exp_port_q) &&
                (in_q.reply_tag == exp_tag_q);
    hit       = type_q && !too_short && match;
    sum_ext   = {sum_q[31], sum_q} + {trip[31], trip};

    sent_d     = sent_q;
    recv_d     = recv_q;
    dup_d      = dup_q;
    min_d      = min_q;
    max_d      = max_q;
    sum_d      = sum_q;
    answered_d = answered_q;
    seq_out    = '0;
    mem_we     = 1'b0;
    mem_waddr  = sent_q[IdxW-1:0];
    mem_wdata  = 1'b0;

    if (!type_q) begin
      if (tx_ok) begin
        status     = StatSent;
        seq_out    = sent_q[15:0];
        sent_d     = sat_inc(sent_q);
        answered_d = 1'b0;
        mem_we     = cmd_i.exec;
      end else begin
        status = StatRefused;
      end
    end else if (too_short) begin
      status = StatTooShort;
    end else if (!match) begin
      status = StatForeign;
    end else begin
      if ((sent_q != '0) && ({16'd0, in_q.reply_seq} == sent_q - 32'd1)) begin
        answered_d = 1'b1;
      end
      // signed saturation of the running sum
      if (sum_ext[32] != sum_ext[31]) begin
        sum_d = sum_ext[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        sum_d = sum_ext[31:0];
      end
      if ($signed(trip) < $signed(min_q)) min_d = trip;
      if ($signed(trip) > $signed(max_q)) max_d = trip;
      if (seen_rd_q) begin
        status = StatDuplicate;
        dup_d  = sat_inc(dup_q);
      end else begin
        status    = StatReplyOk;
        recv_d    = sat_inc(recv_q);
        mem_we    = cmd_i.exec;
        mem_waddr = rd_slot;
        mem_wdata = 1'b1;
      end
    end

    // reset sweep owns the write port
    if (cmd_i.clear_we) begin
      mem_we    = 1'b1;
      mem_waddr = cmd_i.clear_addr;
      mem_wdata = 1'b0;
    end

    limit_hit = (limit_q != '0) && (sent_d == limit_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q     <= '0;
      recv_q     <= '0;
      dup_q      <= '0;
      min_q      <= TripMinReset;
      max_q      <= '0;
      sum_q      <= '0;
      answered_q <= 1'b1;
    end else if (cmd_i.exec) begin
      sent_q     <= sent_d;
      recv_q     <= recv_d;
      dup_q      <= dup_d;
      min_q      <= min_d;
      max_q      <= max_d;
      sum_q      <= sum_d;
      answered_q <= answered_d;
    end
  end

  // output register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [2:0]          out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_status_q <= status;
      out_data_q   <= {6'd0, limit_hit, answered_d, sum_d, max_d, min_d, dup_d, recv_d,
                       sent_d, (hit ? trip : 32'd0), seq_out};
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_data_q;
  assign out_status_o  = out_status_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

// ===== design/echo_reply_tracker.sv =====
// ----------------------------------------------------------------------------
// echo_reply_tracker: echo request and reply tracker
// Numbers outgoing requests, checks incoming replies, flags duplicates
// through a seen bitmap and keeps saturating counters and trip statistics.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_axis    in         tvalid / tready         tuser req_type, tdata frame fields
//  m_axis    out        tvalid / tready         tuser status, tdata counters and stats
//  cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  each item steps through accept, registered bitmap read, update
//  the bitmap memory read port sets the lookup cycle; one item in flight
//  after reset a sweep clears all 1024 bitmap entries, s_axis_tready stays low
//  a stalled m_axis holds the update until the output register frees up
//  cfg writes are taken in every cycle
// ----------------------------------------------------------------------------
module echo_reply_tracker
  import ert_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // frame_length, frame_class, frame_kind, reply_port, reply_tag,
  // reply_seq, sent_time_ms, now_ms
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type
  input  logic                s_axis_tuser,
  // stream out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // seq_out, trip_ms, sent_total, received_total, duplicate_total,
  // min_trip_ms, max_trip_ms, trip_sum_ms, caught_up, limit_hit, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // status
  output logic [2:0]          m_axis_tuser,
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ert_cmd_t cmd;
  ert_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ert_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ert_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (frame_t'(s_axis_tdata)),
    .in_type_i    (s_axis_tuser),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_data_o   (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

  // one item in flight: no accept in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // a sent request always leaves a nonzero sent count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == StatSent)) |-> (m_axis_tdata[79:48] != 32'd0))
    else $error("sent status with zero sent total");

  // a fresh reply always leaves a nonzero received count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == StatReplyOk)) |-> (m_axis_tdata[111:80] != 32'd0))
    else $error("reply ok with zero received total");

  // a refused request carries no sequence number and no trip time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == StatRefused)) |-> (m_axis_tdata[47:0] == 48'd0))
    else $error("refused request with sequence or trip set");

endmodule
